// ===== design/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_cell and round_robin_task_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int TASK_ID_W = 4;
  localparam int SLICE_W   = 8;
  localparam int SLEEP_IN_W = 32;

  // Event codes carried by an input item
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_SLEEP   = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FREE     = 2'd1,
    STAT_BAD_UNBLOCK = 2'd2,
    STAT_ZERO_SLEEP  = 2'd3
  } status_t;

  // Per-slot task state
  typedef enum logic [1:0] {
    TS_READY = 2'd0,
    TS_RUN   = 2'd1,
    TS_BLOCK = 2'd2,
    TS_SLEEP = 2'd3
  } task_state_t;

  // Commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic               create;
    logic               block;
    logic               unblock;
    logic               sleep;
    logic               tick;
    logic               slice_dec;
    logic               slice_load;
    logic               scan;
    logic               use_hi;
    logic               start_ready;
    logic [SLICE_W-1:0] slice_reload;
  } ctl_t;

  // Carries rippled from each cell to its upper neighbour
  typedef struct packed {
    logic hi;    // a ready slot at or above the current slot lies below
    logic all;   // any ready slot lies below
    logic free;  // a free slot lies below
  } chain_t;

  // Status reported by each cell to the sequencer
  typedef struct packed {
    logic used;
    logic run;
    logic slice_zero;
    logic grant;
    logic free_win;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler: sequencer and chain of slots.
// Depends on rrts_pkg and rrts_cell.
// Steps: create, unblock and idle ops go from apply straight to done; a tick that keeps
// the running task goes apply, countdown, done; a tick, block or sleep that scans goes
// apply, countdown, scan, done. Done holds until the output is free, then registers the
// result. One item at a time; the next item is taken the cycle after the result is
// registered. Reset (synchronous): slot 0 runs, slice reload 1.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int NUM_TASKS  = 16,
  parameter int SLEEP_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [SLICE_W-1:0]    cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            op,
  input  wire logic [TASK_ID_W-1:0]  task_id,
  input  wire logic                  start_ready,
  input  wire logic [SLEEP_IN_W-1:0] sleep_ticks,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       switched,
  output logic [TASK_ID_W-1:0]       previous_task,
  output logic [TASK_ID_W-1:0]       current_task,
  output logic [TASK_ID_W-1:0]       created_task,
  output logic [1:0]                 status
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_APPLY = 5'b00010,
    S_TICK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } seq_state_t;

  seq_state_t            state;
  seq_state_t            state_next;
  logic [SLICE_W-1:0]    slice_reload;
  op_t                   op_q;
  logic [TASK_ID_W-1:0]  tid_q;
  logic                  start_q;
  logic [SLEEP_BITS-1:0] ticks_q;
  logic [IW-1:0]         cur;
  logic [IW-1:0]         prev_q;
  logic [IW-1:0]         created_q;
  status_t               status_q;
  logic                  switched_q;

  ctl_t                  ctl;
  chain_t                chain [NUM_TASKS+1];
  cell_stat_t            stat [NUM_TASKS];
  logic [NUM_TASKS-1:0]  cur_oh;
  logic [NUM_TASKS-1:0]  tid_oh;
  logic [NUM_TASKS-1:0]  after;
  logic                  tid_ok;
  logic                  tid_used;
  logic                  cur_used;
  logic                  cur_run;
  logic                  cur_slice_zero;
  logic [IW-1:0]         grant_idx;
  logic [IW-1:0]         free_idx;
  logic                  any_free;
  logic                  any_ready;
  logic                  do_step;
  logic                  out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign tid_ok   = (int'(tid_q) < NUM_TASKS);

  // Decode slot selects and gather cell status
  always_comb begin
    cur_oh         = '0;
    tid_oh         = '0;
    after          = '0;
    tid_used       = 1'b0;
    cur_used       = 1'b0;
    cur_run        = 1'b0;
    cur_slice_zero = 1'b0;
    grant_idx      = '0;
    free_idx       = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      cur_oh[i]      = (int'(cur) == i);
      tid_oh[i]      = tid_ok && (int'(tid_q) == i);
      after[i]       = (i >= int'(cur));
      tid_used       = tid_used | (tid_oh[i] & stat[i].used);
      cur_used       = cur_used | (cur_oh[i] & stat[i].used);
      cur_run        = cur_run | (cur_oh[i] & stat[i].run);
      cur_slice_zero = cur_slice_zero | (cur_oh[i] & stat[i].slice_zero);
      grant_idx      = grant_idx | (stat[i].grant ? IW'(i) : '0);
      free_idx       = free_idx | (stat[i].free_win ? IW'(i) : '0);
    end
  end

  assign any_free  = chain[NUM_TASKS].free;
  assign any_ready = chain[NUM_TASKS].all;
  assign do_step   = (op_q == OP_TICK) || (op_q == OP_BLOCK) ||
                     ((op_q == OP_SLEEP) && (ticks_q != '0));

  // Broadcast command for the current sequencer step
  always_comb begin
    ctl              = '0;
    ctl.start_ready  = start_q;
    ctl.slice_reload = slice_reload;
    ctl.use_hi       = chain[NUM_TASKS].hi;
    unique case (state)
      S_APPLY: begin
        ctl.create  = (op_q == OP_CREATE) && any_free;
        ctl.block   = (op_q == OP_BLOCK);
        ctl.unblock = (op_q == OP_UNBLOCK) && tid_used;
        ctl.sleep   = (op_q == OP_SLEEP) && (ticks_q != '0);
      end
      S_TICK: begin
        ctl.tick       = 1'b1;
        ctl.slice_dec  = cur_run && !cur_slice_zero;
        ctl.slice_load = cur_run && cur_slice_zero;
      end
      S_SCAN: begin
        ctl.scan = any_ready;
      end
      default: begin
      end
    endcase
  end

  // Chain of slot cells
  assign chain[0] = '0;
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    rrts_cell #(
      .IS_KERNEL (g == 0),
      .SLEEP_BITS(SLEEP_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .ticks      (ticks_q),
      .is_cur     (cur_oh[g]),
      .is_tid     (tid_oh[g]),
      .at_or_after(after[g]),
      .chain_in   (chain[g]),
      .chain_out  (chain[g+1]),
      .stat       (stat[g])
    );
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = (do_step && cur_used) ? S_TICK : S_DONE;
      end
      S_TICK: begin
        state_next = (cur_run && !cur_slice_zero) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state, item fields and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slice_reload <= SLICE_W'(1);
      cur          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) slice_reload <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_SCAN && any_ready) cur <= grant_idx;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_q       <= op_t'(op);
        tid_q      <= task_id;
        start_q    <= start_ready;
        ticks_q    <= SLEEP_BITS'(sleep_ticks);
        prev_q     <= cur;
        created_q  <= '0;
        status_q   <= STAT_OK;
        switched_q <= 1'b0;
      end
      S_APPLY: begin
        if (op_q == OP_CREATE) begin
          if (any_free) created_q <= free_idx;
          else          status_q  <= STAT_NO_FREE;
        end
        if (op_q == OP_UNBLOCK && !tid_used) status_q <= STAT_BAD_UNBLOCK;
        if (op_q == OP_SLEEP && ticks_q == '0) status_q <= STAT_ZERO_SLEEP;
      end
      S_SCAN: begin
        switched_q <= any_ready;
      end
      S_DONE: begin
        if (out_free) begin
          switched      <= switched_q;
          previous_task <= TASK_ID_W'(prev_q);
          current_task  <= TASK_ID_W'(cur);
          created_task  <= TASK_ID_W'(created_q);
          status        <= status_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rrts_cell.sv =====
// One task slot of the scheduler: slot state, sleep counter and slice counter.
// Depends on rrts_pkg; chained by round_robin_task_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module rrts_cell import rrts_pkg::*; #(
  parameter bit IS_KERNEL  = 1'b0,
  parameter int SLEEP_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  ctl,
  input  wire logic [SLEEP_BITS-1:0] ticks,
  input  wire logic                  is_cur,
  input  wire logic                  is_tid,
  input  wire logic                  at_or_after,
  input  wire chain_t                chain_in,
  output chain_t                     chain_out,
  output cell_stat_t                 stat
);

  logic                  used;
  task_state_t           st;
  logic [SLEEP_BITS-1:0] sleep_left;
  logic                  in_list;
  logic [SLICE_W-1:0]    slice_left;

  logic                  req;
  logic                  req_hi;
  logic [SLEEP_BITS-1:0] sleep_dec;

  // Request and grant chain
  assign req       = used && (st == TS_READY);
  assign req_hi    = req && at_or_after;
  assign sleep_dec = sleep_left - SLEEP_BITS'(1);

  assign chain_out.hi   = chain_in.hi | req_hi;
  assign chain_out.all  = chain_in.all | req;
  assign chain_out.free = chain_in.free | !used;

  assign stat.used       = used;
  assign stat.run        = (st == TS_RUN);
  assign stat.slice_zero = (slice_left == '0);
  assign stat.grant      = ctl.use_hi ? (req_hi && !chain_in.hi) : (req && !chain_in.all);
  assign stat.free_win   = !used && !chain_in.free;

  // Update slot state from the broadcast command
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= IS_KERNEL;
      st         <= IS_KERNEL ? TS_RUN : TS_READY;
      sleep_left <= '0;
      in_list    <= 1'b0;
      slice_left <= IS_KERNEL ? SLICE_W'(1) : '0;
    end else begin
      if (ctl.create && stat.free_win) begin
        used       <= 1'b1;
        st         <= ctl.start_ready ? TS_READY : TS_RUN;
        slice_left <= ctl.slice_reload;
        sleep_left <= '0;
        in_list    <= 1'b0;
      end
      if (ctl.block && is_cur) begin
        st <= TS_BLOCK;
      end
      if (ctl.unblock && is_tid) begin
        st <= TS_READY;
      end
      if (ctl.sleep && is_cur) begin
        st         <= TS_SLEEP;
        sleep_left <= ticks;
        in_list    <= 1'b1;
      end
      // Count down sleepers other than the current task
      if (ctl.tick && in_list && !is_cur) begin
        sleep_left <= sleep_dec;
        if (sleep_dec == '0) begin
          st      <= TS_READY;
          in_list <= 1'b0;
        end
      end
      if (ctl.slice_dec && is_cur) begin
        slice_left <= slice_left - SLICE_W'(1);
      end
      if (ctl.slice_load && is_cur) begin
        slice_left <= ctl.slice_reload;
      end
      // Dispatch: old running task drops to ready, winner runs
      if (ctl.scan && stat.grant) begin
        st <= TS_RUN;
      end else if (ctl.scan && is_cur && (st == TS_RUN)) begin
        st <= TS_READY;
      end
    end
  end

endmodule

`default_nettype wire
